@@ hw/rtl/hit_pair_consistency_separation_macros.svh @@
// ----------------------------------------------------------------------------
// Hit pair consistency separation: assertion macros
// Shared concurrent check forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HIT_PAIR_CONSISTENCY_SEPARATION_MACROS_SVH
`define HIT_PAIR_CONSISTENCY_SEPARATION_MACROS_SVH

// same-cycle implication
`define HPCS_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HPCS_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/hpcs_pkg.sv @@
// ----------------------------------------------------------------------------
// hpcs_pkg
// Shared constants, types and scale tables for the hit pair separation block.
// ----------------------------------------------------------------------------
`default_nettype none
package hpcs_pkg;

   localparam int WIRE_BITS_DEF = 13;
   localparam int POS_BITS_DEF  = 20;

   localparam int TIME_BITS  = 18;
   localparam int SCALE_BITS = 12;
   localparam int MINOV_BITS = 8;
   localparam int MASK_BITS  = 3;
   localparam int FRAC_SHIFT = 8;
   localparam int WIN_BITS   = SCALE_BITS + TIME_BITS;
   localparam int TW_BITS    = WIN_BITS + 2;
   localparam int OV_BITS    = WIN_BITS + 1;
   localparam int SEP_BITS   = 24;
   localparam int K_BITS     = 3;
   localparam int P11_BITS   = 21;
   localparam int P10_BITS   = 20;
   localparam int ADDR_BITS  = 3;
   localparam int DATA_BITS  = 32;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 12'd768;
   localparam logic [MINOV_BITS-1:0] MINOV_RESET = 8'd6;
   localparam logic [SEP_BITS-1:0]   SEP_MAX     = {SEP_BITS{1'b1}};
   localparam logic [K_BITS-1:0]     SLOTS       = 3'd6;

   localparam int NB_NEAR = 2;
   localparam int NB_MID  = 3;
   localparam int NB_FAR  = 8;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPARE = 1'b1;

   localparam logic [0:0] REG_SCALE = 1'b0;
   localparam logic [0:0] REG_MINOV = 1'b1;

   typedef struct packed {
      logic              pass;
      logic              ovok;
      logic              sat;
      logic [K_BITS-1:0] k;
   } hpcs_ctl_type;

   localparam int CTL_BITS = $bits(hpcs_ctl_type);

   function automatic logic [P11_BITS-1:0] pow11(input logic [K_BITS-1:0] k);
      logic [P11_BITS-1:0] r;
      case (k)
         3'd0:    r = 21'd1;
         3'd1:    r = 21'd11;
         3'd2:    r = 21'd121;
         3'd3:    r = 21'd1331;
         3'd4:    r = 21'd14641;
         3'd5:    r = 21'd161051;
         3'd6:    r = 21'd1771561;
         default: r = 21'd1;
      endcase
      return r;
   endfunction

   function automatic logic [P10_BITS-1:0] pow10(input logic [K_BITS-1:0] k);
      logic [P10_BITS-1:0] r;
      case (k)
         3'd0:    r = 20'd1;
         3'd1:    r = 20'd10;
         3'd2:    r = 20'd100;
         3'd3:    r = 20'd1000;
         3'd4:    r = 20'd10000;
         3'd5:    r = 20'd100000;
         3'd6:    r = 20'd1000000;
         default: r = 20'd1;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hpcs_front.sv @@
// ----------------------------------------------------------------------------
// hpcs_front
// Reference pair store, time windows, overlap, sorted wire deltas,
// neighbour test and squared distance; four register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module hpcs_front import hpcs_pkg::*; #(
   parameter int POS_BITS  = POS_BITS_DEF,
   parameter int WIRE_BITS = WIRE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_accept,
   input  logic                        in_op,
   input  logic [TIME_BITS-1:0]        in_peak_time,
   input  logic [TIME_BITS-1:0]        in_sigma_time,
   input  logic signed [POS_BITS-1:0]  in_pos_x,
   input  logic signed [POS_BITS-1:0]  in_pos_y,
   input  logic signed [POS_BITS-1:0]  in_pos_z,
   input  logic [WIRE_BITS-1:0]        in_wire_u,
   input  logic [WIRE_BITS-1:0]        in_wire_v,
   input  logic [WIRE_BITS-1:0]        in_wire_w,
   input  logic [MASK_BITS-1:0]        in_hit_mask,
   input  logic [SCALE_BITS-1:0]       scale,
   input  logic [MINOV_BITS-1:0]       min_overlap,
   output logic                        out_valid,
   output logic [2*POS_BITS+1:0]       out_radicand,
   output hpcs_ctl_type                out_ctl,
   output logic [WIN_BITS-1:0]         out_minw,
   output logic [OV_BITS-1:0]          out_overlap,
   output logic [WIRE_BITS-1:0]        out_dmin,
   output logic [WIRE_BITS-1:0]        out_dmid,
   output logic [WIRE_BITS-1:0]        out_dmax
);

   localparam int AD_BITS = POS_BITS + 1;
   localparam int SQ_BITS = 2 * AD_BITS;

   logic signed [POS_BITS-1:0] pos_in [3];
   logic [WIRE_BITS-1:0]       wire_in [3];

   logic [TIME_BITS-1:0]       ref_peak_ff;
   logic [TIME_BITS-1:0]       ref_sigma_ff;
   logic signed [POS_BITS-1:0] ref_pos_ff [3];
   logic [WIRE_BITS-1:0]       ref_wire_ff [3];
   logic [MASK_BITS-1:0]       ref_mask_ff;

   // stage 1
   logic                 v1_ff;
   logic [WIN_BITS-1:0]  w1_ff, w2_ff, w1_in, w2_in;
   logic [TIME_BITS-1:0] ptr1_ff, pt1_ff;
   logic [AD_BITS-1:0]   ad1_ff [3];
   logic [AD_BITS-1:0]   ad1_in [3];
   logic [WIRE_BITS-1:0] dw1_ff [3];
   logic [WIRE_BITS-1:0] dw1_in [3];
   logic [K_BITS-1:0]    k1_ff, k1_in;

   // stage 2
   logic                      v2_ff;
   logic signed [TW_BITS-1:0] up1_ff, lo1_ff, up2_ff, lo2_ff;
   logic signed [TW_BITS-1:0] tr_in, tc_in;
   logic [WIN_BITS-1:0]       minw2_ff;
   logic [SQ_BITS-1:0]        sq2_ff [3];
   logic [WIRE_BITS-1:0]      dmin2_ff, dmid2_ff, dmax2_ff;
   logic [WIRE_BITS-1:0]      sa_in, sb_in, sc_in, st_in;
   logic [K_BITS-1:0]         k2_ff;

   // stage 3
   logic                      v3_ff;
   logic signed [TW_BITS-1:0] upper_in, lower_in;
   logic signed [TW_BITS:0]   ov3_ff, ov3_in;
   logic [SQ_BITS-1:0]        rad3_ff;
   logic [WIN_BITS-1:0]       minw3_ff;
   logic [WIRE_BITS-1:0]      dmin3_ff, dmid3_ff, dmax3_ff;
   logic [K_BITS-1:0]         k3_ff;

   // stage 4
   logic                 v4_ff;
   logic [SQ_BITS-1:0]   rad4_ff;
   hpcs_ctl_type         ctl4_ff, ctl4_in;
   logic [WIN_BITS-1:0]  minw4_ff;
   logic [OV_BITS-1:0]   ov4_ff;
   logic [WIRE_BITS-1:0] dmin4_ff, dmid4_ff, dmax4_ff;
   logic                 ovok_in, near_in;

   assign pos_in  = '{in_pos_x, in_pos_y, in_pos_z};
   assign wire_in = '{in_wire_u, in_wire_v, in_wire_w};

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_peak_ff  <= '0;
         ref_sigma_ff <= '0;
         ref_mask_ff  <= '0;
         for (int i = 0; i < 3; i++) begin
            ref_pos_ff[i]  <= '0;
            ref_wire_ff[i] <= '0;
         end
      end else if (in_accept && in_op == OP_LOAD) begin
         ref_peak_ff  <= in_peak_time;
         ref_sigma_ff <= in_sigma_time;
         ref_mask_ff  <= in_hit_mask;
         for (int i = 0; i < 3; i++) begin
            ref_pos_ff[i]  <= pos_in[i];
            ref_wire_ff[i] <= wire_in[i];
         end
      end
   end

   // stage 1: half widths, position and wire differences, empty slots
   always_comb begin
      logic signed [AD_BITS-1:0] diff;
      w1_in = scale * ref_sigma_ff;
      w2_in = scale * in_sigma_time;
      for (int i = 0; i < 3; i++) begin
         diff = {ref_pos_ff[i][POS_BITS-1], ref_pos_ff[i]}
              - {pos_in[i][POS_BITS-1], pos_in[i]};
         ad1_in[i] = diff[AD_BITS-1] ? AD_BITS'(-diff) : AD_BITS'(diff);
         dw1_in[i] = (ref_wire_ff[i] > wire_in[i]) ? ref_wire_ff[i] - wire_in[i]
                                                   : wire_in[i] - ref_wire_ff[i];
      end
      k1_in = SLOTS
            - K_BITS'(ref_mask_ff[0]) - K_BITS'(ref_mask_ff[1]) - K_BITS'(ref_mask_ff[2])
            - K_BITS'(in_hit_mask[0]) - K_BITS'(in_hit_mask[1]) - K_BITS'(in_hit_mask[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_accept && in_op == OP_COMPARE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w1_ff   <= w1_in;
         w2_ff   <= w2_in;
         ptr1_ff <= ref_peak_ff;
         pt1_ff  <= in_peak_time;
         ad1_ff  <= ad1_in;
         dw1_ff  <= dw1_in;
         k1_ff   <= k1_in;
      end
   end

   // stage 2: window ends, squares, delta sort
   always_comb begin
      tr_in = signed'(TW_BITS'({ptr1_ff, {FRAC_SHIFT{1'b0}}}));
      tc_in = signed'(TW_BITS'({pt1_ff, {FRAC_SHIFT{1'b0}}}));
      st_in = '0;
      sa_in = dw1_ff[0];
      sb_in = dw1_ff[1];
      sc_in = dw1_ff[2];
      if (sa_in > sb_in) begin
         st_in = sa_in; sa_in = sb_in; sb_in = st_in;
      end
      if (sb_in > sc_in) begin
         st_in = sb_in; sb_in = sc_in; sc_in = st_in;
      end
      if (sa_in > sb_in) begin
         st_in = sa_in; sa_in = sb_in; sb_in = st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         up1_ff   <= tr_in + signed'(TW_BITS'(w1_ff));
         lo1_ff   <= tr_in - signed'(TW_BITS'(w1_ff));
         up2_ff   <= tc_in + signed'(TW_BITS'(w2_ff));
         lo2_ff   <= tc_in - signed'(TW_BITS'(w2_ff));
         minw2_ff <= (w1_ff < w2_ff) ? w1_ff : w2_ff;
         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= ad1_ff[i] * ad1_ff[i];
         end
         dmin2_ff <= sa_in;
         dmid2_ff <= sb_in;
         dmax2_ff <= sc_in;
         k2_ff    <= k1_ff;
      end
   end

   // stage 3: overlap and distance sum
   always_comb begin
      upper_in = (up1_ff < up2_ff) ? up1_ff : up2_ff;
      lower_in = (lo1_ff > lo2_ff) ? lo1_ff : lo2_ff;
      ov3_in   = {upper_in[TW_BITS-1], upper_in} - {lower_in[TW_BITS-1], lower_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ov3_ff   <= ov3_in;
         rad3_ff  <= sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
         minw3_ff <= minw2_ff;
         dmin3_ff <= dmin2_ff;
         dmid3_ff <= dmid2_ff;
         dmax3_ff <= dmax2_ff;
         k3_ff    <= k2_ff;
      end
   end

   // stage 4: overlap and neighbour tests
   always_comb begin
      ovok_in = !ov3_ff[TW_BITS]
             && (ov3_ff[TW_BITS-1:0] > TW_BITS'({min_overlap, {FRAC_SHIFT{1'b0}}}));
      near_in = (dmin3_ff < WIRE_BITS'(NB_NEAR) && dmid3_ff < WIRE_BITS'(NB_NEAR))
             || (dmin3_ff < WIRE_BITS'(NB_NEAR) && dmid3_ff < WIRE_BITS'(NB_MID)
                 && dmax3_ff < WIRE_BITS'(NB_FAR));
      ctl4_in.pass = ovok_in && near_in;
      ctl4_in.ovok = ovok_in;
      ctl4_in.sat  = 1'b0;
      ctl4_in.k    = k3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad4_ff  <= rad3_ff;
         ctl4_ff  <= ctl4_in;
         minw4_ff <= minw3_ff;
         ov4_ff   <= ov3_ff[OV_BITS-1:0];
         dmin4_ff <= dmin3_ff;
         dmid4_ff <= dmid3_ff;
         dmax4_ff <= dmax3_ff;
      end
   end

   assign out_valid    = v4_ff;
   assign out_radicand = rad4_ff;
   assign out_ctl      = ctl4_ff;
   assign out_minw     = minw4_ff;
   assign out_overlap  = ov4_ff;
   assign out_dmin     = dmin4_ff;
   assign out_dmid     = dmid4_ff;
   assign out_dmax     = dmax4_ff;

endmodule
`default_nettype wire

@@ hw/rtl/hpcs_sqrt.sv @@
// ----------------------------------------------------------------------------
// hpcs_sqrt
// Pipelined integer square root, one root bit per stage, side data carried.
// ----------------------------------------------------------------------------
`default_nettype none
module hpcs_sqrt import hpcs_pkg::*; #(
   parameter int RT_BITS = POS_BITS_DEF + 1,
   parameter int S_BITS  = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [2*RT_BITS-1:0]   in_radicand,
   input  logic [S_BITS-1:0]      in_side,
   output logic                   out_valid,
   output logic [RT_BITS-1:0]     out_root,
   output logic [S_BITS-1:0]      out_side
);

   localparam int R_BITS = 2 * RT_BITS;

   logic               valid_ff [RT_BITS];
   logic [R_BITS-1:0]  res_ff   [RT_BITS];
   logic [RT_BITS-1:0] root_ff  [RT_BITS];
   logic [S_BITS-1:0]  side_ff  [RT_BITS];

   for (genvar j = 0; j < RT_BITS; j++) begin : g_stage
      localparam int B = RT_BITS - 1 - j;
      logic               valid_cur;
      logic [R_BITS-1:0]  res_cur, trial, res_in;
      logic [RT_BITS-1:0] root_cur, root_in;
      logic [S_BITS-1:0]  side_cur;
      logic               take;

      if (j == 0) begin : g_first
         assign valid_cur = in_valid;
         assign res_cur   = in_radicand;
         assign root_cur  = '0;
         assign side_cur  = in_side;
      end else begin : g_next
         assign valid_cur = valid_ff[j-1];
         assign res_cur   = res_ff[j-1];
         assign root_cur  = root_ff[j-1];
         assign side_cur  = side_ff[j-1];
      end

      always_comb begin
         trial   = (R_BITS'(root_cur) << (B + 1)) + (R_BITS'(1) << (2 * B));
         take    = res_cur >= trial;
         res_in  = take ? res_cur - trial : res_cur;
         root_in = root_cur;
         root_in[B] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            res_ff[j]  <= res_in;
            root_ff[j] <= root_in;
            side_ff[j] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[RT_BITS-1];
   assign out_root  = root_ff[RT_BITS-1];
   assign out_side  = side_ff[RT_BITS-1];

endmodule
`default_nettype wire

@@ hw/rtl/hpcs_div.sv @@
// ----------------------------------------------------------------------------
// hpcs_div
// Pipelined restoring divider, one quotient bit per stage, side data carried.
// Dividend must be below divisor shifted left by the quotient width.
// ----------------------------------------------------------------------------
`default_nettype none
module hpcs_div import hpcs_pkg::*; #(
   parameter int N_BITS = 2 * SEP_BITS,
   parameter int D_BITS = SEP_BITS,
   parameter int Q_BITS = SEP_BITS,
   parameter int S_BITS = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [N_BITS-1:0] in_num,
   input  logic [D_BITS-1:0] in_den,
   input  logic [S_BITS-1:0] in_side,
   output logic              out_valid,
   output logic [Q_BITS-1:0] out_quot,
   output logic [S_BITS-1:0] out_side
);

   logic              valid_ff [Q_BITS];
   logic [N_BITS-1:0] rem_ff   [Q_BITS];
   logic [D_BITS-1:0] den_ff   [Q_BITS];
   logic [Q_BITS-1:0] quot_ff  [Q_BITS];
   logic [S_BITS-1:0] side_ff  [Q_BITS];

   for (genvar j = 0; j < Q_BITS; j++) begin : g_stage
      localparam int B = Q_BITS - 1 - j;
      logic              valid_cur;
      logic [N_BITS-1:0] rem_cur, trial, rem_in;
      logic [D_BITS-1:0] den_cur;
      logic [Q_BITS-1:0] quot_cur, quot_in;
      logic [S_BITS-1:0] side_cur;
      logic              take;

      if (j == 0) begin : g_first
         assign valid_cur = in_valid;
         assign rem_cur   = in_num;
         assign den_cur   = in_den;
         assign quot_cur  = '0;
         assign side_cur  = in_side;
      end else begin : g_next
         assign valid_cur = valid_ff[j-1];
         assign rem_cur   = rem_ff[j-1];
         assign den_cur   = den_ff[j-1];
         assign quot_cur  = quot_ff[j-1];
         assign side_cur  = side_ff[j-1];
      end

      always_comb begin
         trial   = N_BITS'(den_cur) << B;
         take    = rem_cur >= trial;
         rem_in  = take ? rem_cur - trial : rem_cur;
         quot_in = quot_cur;
         quot_in[B] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            den_ff[j]  <= den_cur;
            quot_ff[j] <= quot_in;
            side_ff[j] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[Q_BITS-1];
   assign out_quot  = quot_ff[Q_BITS-1];
   assign out_side  = side_ff[Q_BITS-1];

endmodule
`default_nettype wire

@@ hw/rtl/hit_pair_consistency_separation.sv @@
// ----------------------------------------------------------------------------
// hit_pair_consistency_separation
// Time-window consistency, wire neighbour test and weighted separation of a
// 3D hit pair against a stored reference pair.
// ----------------------------------------------------------------------------
// A load transaction (op 0) replaces the reference pair at once and gives no
// result; a compare transaction (op 1) gives one result, in order. A new
// transaction is taken every cycle in which the result register is empty or
// being taken. The path from acceptance to result runs through four front
// stages, one stage per root bit of the distance square root, one stage per
// quotient bit in the 1.1^k divider (25) and in the width/overlap divider (24),
// plus the scaling multiply stages and the output register. The whole pipeline
// holds while a result is waiting to be taken.
`default_nettype none
`include "hit_pair_consistency_separation_macros.svh"
module hit_pair_consistency_separation import hpcs_pkg::*; #(
   parameter int WIRE_BITS = WIRE_BITS_DEF,
   parameter int POS_BITS  = POS_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_op,
   input  logic [TIME_BITS-1:0]       req_peak_time,
   input  logic [TIME_BITS-1:0]       req_sigma_time,
   input  logic signed [POS_BITS-1:0] req_pos_x,
   input  logic signed [POS_BITS-1:0] req_pos_y,
   input  logic signed [POS_BITS-1:0] req_pos_z,
   input  logic [WIRE_BITS-1:0]       req_wire_u,
   input  logic [WIRE_BITS-1:0]       req_wire_v,
   input  logic [WIRE_BITS-1:0]       req_wire_w,
   input  logic [MASK_BITS-1:0]       req_hit_mask,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_consistent,
   output logic [SEP_BITS-1:0]        rsp_separation,
   output logic [WIRE_BITS-1:0]       rsp_delta_min,
   output logic [WIRE_BITS-1:0]       rsp_delta_mid,
   output logic [WIRE_BITS-1:0]       rsp_delta_max,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ADDR_BITS-1:0]       paddr,
   input  logic [DATA_BITS-1:0]       pwdata,
   output logic [DATA_BITS-1:0]       prdata,
   output logic                       pready
);

   localparam int RT_BITS = POS_BITS + 1;
   localparam int RX_BITS = (RT_BITS > SEP_BITS) ? RT_BITS : SEP_BITS + 1;
   localparam int S1_BITS = CTL_BITS + WIN_BITS + OV_BITS + 3 * WIRE_BITS;
   localparam int S2_BITS = CTL_BITS + 3 * WIRE_BITS;
   localparam int N1_BITS = SEP_BITS + P11_BITS;
   localparam int Q1_BITS = SEP_BITS + 1;
   localparam int N2_BITS = SEP_BITS + OV_BITS;

   logic adv, accept;

   logic [SCALE_BITS-1:0] scale_ff;
   logic [MINOV_BITS-1:0] minov_ff;

   // front outputs
   logic                  fr_valid;
   logic [2*RT_BITS-1:0]  fr_radicand;
   hpcs_ctl_type          fr_ctl;
   logic [WIN_BITS-1:0]   fr_minw;
   logic [OV_BITS-1:0]    fr_ov;
   logic [WIRE_BITS-1:0]  fr_dmin, fr_dmid, fr_dmax;

   // square root outputs
   logic                  sq_valid;
   logic [RT_BITS-1:0]    sq_root;
   logic [S1_BITS-1:0]    sq_side;
   hpcs_ctl_type          sq_ctl;
   logic [WIN_BITS-1:0]   sq_minw;
   logic [OV_BITS-1:0]    sq_ov;
   logic [3*WIRE_BITS-1:0] sq_d;
   logic [RX_BITS-1:0]    root_x;

   // scale stage
   logic                  p1_valid_ff;
   logic [N1_BITS-1:0]    p1_num_ff;
   logic [P10_BITS-1:0]   p1_den_ff;
   logic [S1_BITS-1:0]    p1_side_ff;
   hpcs_ctl_type          p1_ctl_in;

   // first divider outputs
   logic                  d1_valid;
   logic [Q1_BITS-1:0]    d1_quot;
   logic [S1_BITS-1:0]    d1_side;
   hpcs_ctl_type          d1_ctl;
   logic [WIN_BITS-1:0]   d1_minw;
   logic [OV_BITS-1:0]    d1_ov;
   logic [3*WIRE_BITS-1:0] d1_d;

   // width product and saturation check
   logic                  p2_valid_ff;
   logic [N2_BITS-1:0]    p2_num_ff;
   logic [OV_BITS-1:0]    p2_ov_ff;
   hpcs_ctl_type          p2_ctl_ff, p2_ctl_in;
   logic [3*WIRE_BITS-1:0] p2_d_ff;

   logic                  p3_valid_ff;
   logic [N2_BITS-1:0]    p3_num_ff;
   logic [OV_BITS-1:0]    p3_ov_ff;
   hpcs_ctl_type          p3_ctl_ff, p3_ctl_in;
   logic [3*WIRE_BITS-1:0] p3_d_ff;

   // second divider outputs
   logic                  d2_valid;
   logic [SEP_BITS-1:0]   d2_quot;
   logic [S2_BITS-1:0]    d2_side;
   hpcs_ctl_type          d2_ctl;
   logic [WIRE_BITS-1:0]  d2_dmin, d2_dmid, d2_dmax;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_consistent_ff;
   logic [SEP_BITS-1:0]   rsp_separation_ff, rsp_separation_in;
   logic [WIRE_BITS-1:0]  rsp_dmin_ff, rsp_dmid_ff, rsp_dmax_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   // configuration
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         minov_ff <= MINOV_RESET;
      end else if (psel && penable && pwrite && pready) begin
         unique case (paddr[2])
            REG_SCALE: scale_ff <= pwdata[SCALE_BITS-1:0];
            REG_MINOV: minov_ff <= pwdata[MINOV_BITS-1:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_SCALE: prdata = DATA_BITS'(scale_ff);
         REG_MINOV: prdata = DATA_BITS'(minov_ff);
         default:   prdata = '0;
      endcase
   end

   hpcs_front #(
      .POS_BITS  (POS_BITS),
      .WIRE_BITS (WIRE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (adv),
      .in_accept     (accept),
      .in_op         (req_op),
      .in_peak_time  (req_peak_time),
      .in_sigma_time (req_sigma_time),
      .in_pos_x      (req_pos_x),
      .in_pos_y      (req_pos_y),
      .in_pos_z      (req_pos_z),
      .in_wire_u     (req_wire_u),
      .in_wire_v     (req_wire_v),
      .in_wire_w     (req_wire_w),
      .in_hit_mask   (req_hit_mask),
      .scale         (scale_ff),
      .min_overlap   (minov_ff),
      .out_valid     (fr_valid),
      .out_radicand  (fr_radicand),
      .out_ctl       (fr_ctl),
      .out_minw      (fr_minw),
      .out_overlap   (fr_ov),
      .out_dmin      (fr_dmin),
      .out_dmid      (fr_dmid),
      .out_dmax      (fr_dmax)
   );

   hpcs_sqrt #(
      .RT_BITS (RT_BITS),
      .S_BITS  (S1_BITS)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (fr_valid),
      .in_radicand (fr_radicand),
      .in_side     ({fr_ctl, fr_minw, fr_ov, fr_dmin, fr_dmid, fr_dmax}),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   assign {sq_ctl, sq_minw, sq_ov, sq_d} = sq_side;
   assign root_x = RX_BITS'(sq_root);

   always_comb begin
      p1_ctl_in     = sq_ctl;
      p1_ctl_in.sat = |root_x[RX_BITS-1:SEP_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_num_ff  <= root_x[SEP_BITS-1:0] * pow11(sq_ctl.k);
         p1_den_ff  <= pow10(sq_ctl.k);
         p1_side_ff <= {p1_ctl_in, sq_minw, sq_ov, sq_d};
      end
   end

   hpcs_div #(
      .N_BITS (N1_BITS),
      .D_BITS (P10_BITS),
      .Q_BITS (Q1_BITS),
      .S_BITS (S1_BITS)
   ) u_div_slots (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (p1_valid_ff),
      .in_num    (p1_num_ff),
      .in_den    (p1_den_ff),
      .in_side   (p1_side_ff),
      .out_valid (d1_valid),
      .out_quot  (d1_quot),
      .out_side  (d1_side)
   );

   assign {d1_ctl, d1_minw, d1_ov, d1_d} = d1_side;

   always_comb begin
      p2_ctl_in     = d1_ctl;
      p2_ctl_in.sat = d1_ctl.sat || d1_quot[SEP_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_num_ff <= d1_quot[SEP_BITS-1:0] * {d1_minw, 1'b0};
         p2_ov_ff  <= d1_ov;
         p2_ctl_ff <= p2_ctl_in;
         p2_d_ff   <= d1_d;
      end
   end

   always_comb begin
      p3_ctl_in     = p2_ctl_ff;
      p3_ctl_in.sat = p2_ctl_ff.sat || (p2_num_ff >= {p2_ov_ff, {SEP_BITS{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_num_ff <= p2_num_ff;
         p3_ov_ff  <= p2_ov_ff;
         p3_ctl_ff <= p3_ctl_in;
         p3_d_ff   <= p2_d_ff;
      end
   end

   hpcs_div #(
      .N_BITS (N2_BITS),
      .D_BITS (OV_BITS),
      .Q_BITS (SEP_BITS),
      .S_BITS (S2_BITS)
   ) u_div_width (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (p3_valid_ff),
      .in_num    (p3_num_ff),
      .in_den    (p3_ov_ff),
      .in_side   ({p3_ctl_ff, p3_d_ff}),
      .out_valid (d2_valid),
      .out_quot  (d2_quot),
      .out_side  (d2_side)
   );

   assign {d2_ctl, d2_dmin, d2_dmid, d2_dmax} = d2_side;

   always_comb begin
      if (!d2_ctl.pass) begin
         rsp_separation_in = '0;
      end else if (d2_ctl.sat) begin
         rsp_separation_in = SEP_MAX;
      end else begin
         rsp_separation_in = d2_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_consistent_ff <= d2_ctl.pass;
         rsp_separation_ff <= rsp_separation_in;
         rsp_dmin_ff       <= d2_ctl.ovok ? d2_dmin : '0;
         rsp_dmid_ff       <= d2_ctl.ovok ? d2_dmid : '0;
         rsp_dmax_ff       <= d2_ctl.ovok ? d2_dmax : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_consistent = rsp_consistent_ff;
   assign rsp_separation = rsp_separation_ff;
   assign rsp_delta_min  = rsp_dmin_ff;
   assign rsp_delta_mid  = rsp_dmid_ff;
   assign rsp_delta_max  = rsp_dmax_ff;

   `HPCS_CHECK(a_zero_sep, rsp_valid && !rsp_consistent, rsp_separation == '0,
      "separation nonzero on inconsistent result")
   `HPCS_CHECK(a_near, rsp_valid && rsp_consistent,
      rsp_delta_min < WIRE_BITS'(NB_NEAR) && rsp_delta_mid < WIRE_BITS'(NB_MID),
      "consistent result fails neighbour test")
   `HPCS_CHECK(a_sorted, rsp_valid,
      rsp_delta_min <= rsp_delta_mid && rsp_delta_mid <= rsp_delta_max,
      "wire deltas out of order")
   `HPCS_CHECK_NEXT(a_hold, !adv, $stable(sq_valid) && $stable(d1_valid),
      "pipeline moved during stall")

endmodule
`default_nettype wire

@@ bench/hpcs_checker.sv @@
// ----------------------------------------------------------------------------
// hpcs_checker
// Watches the request, response and register ports of the hit pair block,
// predicts each compare result from its own copy of the reference pair and
// registers, and compares every response field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module hpcs_checker import hpcs_pkg::*; #(
   parameter int WB = WIRE_BITS_DEF,
   parameter int PB = POS_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_op,
   input  logic [TIME_BITS-1:0]  req_peak_time,
   input  logic [TIME_BITS-1:0]  req_sigma_time,
   input  logic signed [PB-1:0]  req_pos_x,
   input  logic signed [PB-1:0]  req_pos_y,
   input  logic signed [PB-1:0]  req_pos_z,
   input  logic [WB-1:0]         req_wire_u,
   input  logic [WB-1:0]         req_wire_v,
   input  logic [WB-1:0]         req_wire_w,
   input  logic [MASK_BITS-1:0]  req_hit_mask,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_consistent,
   input  logic [SEP_BITS-1:0]   rsp_separation,
   input  logic [WB-1:0]         rsp_delta_min,
   input  logic [WB-1:0]         rsp_delta_mid,
   input  logic [WB-1:0]         rsp_delta_max,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_BITS-1:0]  paddr,
   input  logic [DATA_BITS-1:0]  pwdata,
   input  logic                  pready,
   output int                    errors,
   output int                    pending
);

   typedef struct packed {
      logic               consistent;
      logic [SEP_BITS-1:0] separation;
      logic [WB-1:0]       dmin;
      logic [WB-1:0]       dmid;
      logic [WB-1:0]       dmax;
   } sep_result_type;

   sep_result_type expected_seps[$];

   logic [SCALE_BITS-1:0] width_scale;
   logic [MINOV_BITS-1:0] overlap_floor;
   logic [TIME_BITS-1:0]  anchor_peak;
   logic [TIME_BITS-1:0]  anchor_sigma;
   logic signed [PB-1:0]  anchor_pos [3];
   logic [WB-1:0]         anchor_wire [3];
   logic [MASK_BITS-1:0]  anchor_mask;

   function automatic sep_result_type compute_separation(
      input logic [TIME_BITS-1:0] pt, input logic [TIME_BITS-1:0] sg,
      input logic signed [PB-1:0] px, input logic signed [PB-1:0] py,
      input logic signed [PB-1:0] pz, input logic [WB-1:0] wu,
      input logic [WB-1:0] wv, input logic [WB-1:0] ww, input logic [2:0] mask);
      sep_result_type r;
      longint w1, w2, up1, up2, lo1, lo2, upper, lower, ovl, x, y, ad;
      longint unsigned sq, root, t, span, num, den, a, minw, sep;
      int d [3];
      int tmp, k;
      logic signed [PB-1:0] p [3];
      logic [WB-1:0] w [3];
      r = '0;
      p[0] = px; p[1] = py; p[2] = pz;
      w[0] = wu; w[1] = wv; w[2] = ww;
      w1 = longint'(width_scale) * longint'(anchor_sigma);
      w2 = longint'(width_scale) * longint'(sg);
      up1 = (longint'(anchor_peak) << 8) + w1;
      lo1 = (longint'(anchor_peak) << 8) - w1;
      up2 = (longint'(pt) << 8) + w2;
      lo2 = (longint'(pt) << 8) - w2;
      upper = up1 < up2 ? up1 : up2;
      lower = lo1 > lo2 ? lo1 : lo2;
      ovl = upper - lower;
      if (ovl > (longint'(overlap_floor) << 8)) begin
         for (int i = 0; i < 3; i++) begin
            d[i] = int'(anchor_wire[i]) - int'(w[i]);
            if (d[i] < 0) d[i] = -d[i];
         end
         if (d[0] > d[1]) begin tmp = d[0]; d[0] = d[1]; d[1] = tmp; end
         if (d[1] > d[2]) begin tmp = d[1]; d[1] = d[2]; d[2] = tmp; end
         if (d[0] > d[1]) begin tmp = d[0]; d[0] = d[1]; d[1] = tmp; end
         r.dmin = WB'(d[0]); r.dmid = WB'(d[1]); r.dmax = WB'(d[2]);
         if ((d[0] < 2 && d[1] < 2) || (d[0] < 2 && d[1] < 3 && d[2] < 8)) begin
            r.consistent = 1'b1;
            sq = 0;
            for (int i = 0; i < 3; i++) begin
               x = anchor_pos[i];
               y = p[i];
               ad = x > y ? x - y : y - x;
               sq += longint'(ad) * longint'(ad);
            end
            root = 0;
            for (int b = 24; b >= 0; b--) begin
               t = root | (64'd1 << b);
               if (t * t <= sq) root = t;
            end
            span = root;
            k = 6 - $countones(anchor_mask) - $countones(mask);
            num = 1; den = 1;
            for (int i = 0; i < k; i++) begin
               num *= 11; den *= 10;
            end
            a = span * num / den;
            minw = w1 < w2 ? w1 : w2;
            if (a > SEP_MAX || ovl <= 0) sep = SEP_MAX;
            else begin
               sep = (a * 2 * minw) / longint'(ovl);
               if (sep > SEP_MAX) sep = SEP_MAX;
            end
            r.separation = SEP_BITS'(sep);
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      sep_result_type exp_r;
      if (reset) begin
         width_scale   = SCALE_RESET;
         overlap_floor = MINOV_RESET;
         anchor_peak   = '0;
         anchor_sigma  = '0;
         anchor_mask   = '0;
         for (int i = 0; i < 3; i++) begin
            anchor_pos[i]  = '0;
            anchor_wire[i] = '0;
         end
         expected_seps.delete();
         errors  <= 0;
         pending <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == 3'(REG_SCALE) * 4) width_scale = pwdata[SCALE_BITS-1:0];
            else if (paddr == 3'(REG_MINOV) * 4) overlap_floor = pwdata[MINOV_BITS-1:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_seps.size() == 0) begin
               $display("%0t unexpected response transaction", $time);
               errors <= errors + 1;
            end else begin
               exp_r = expected_seps[0];
               expected_seps.delete(0);
               if (exp_r !== {rsp_consistent, rsp_separation, rsp_delta_min,
                              rsp_delta_mid, rsp_delta_max}) begin
                  $display("%0t mismatch exp c=%0d sep=%0d d=%0d/%0d/%0d",
                     $time, exp_r.consistent, exp_r.separation, exp_r.dmin,
                     exp_r.dmid, exp_r.dmax);
                  $display("%0t          act c=%0d sep=%0d d=%0d/%0d/%0d",
                     $time, rsp_consistent, rsp_separation, rsp_delta_min,
                     rsp_delta_mid, rsp_delta_max);
                  errors <= errors + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_op == OP_LOAD) begin
               anchor_peak  = req_peak_time;
               anchor_sigma = req_sigma_time;
               anchor_pos[0] = req_pos_x;
               anchor_pos[1] = req_pos_y;
               anchor_pos[2] = req_pos_z;
               anchor_wire[0] = req_wire_u;
               anchor_wire[1] = req_wire_v;
               anchor_wire[2] = req_wire_w;
               anchor_mask  = req_hit_mask;
            end else begin
               expected_seps.insert(expected_seps.size(),
                  compute_separation(req_peak_time, req_sigma_time, req_pos_x,
                  req_pos_y, req_pos_z, req_wire_u, req_wire_v, req_wire_w,
                  req_hit_mask));
            end
         end
         pending <= expected_seps.size();
      end
   end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives hit pair load and compare transactions and register writes into the
// hit pair separation block under random bursts and response stalls, and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb;
   import hpcs_pkg::*;

   localparam int WB = WIRE_BITS_DEF;
   localparam int PB = POS_BITS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE = 120;

   typedef struct {
      logic                 op;
      logic [TIME_BITS-1:0] pt;
      logic [TIME_BITS-1:0] sg;
      logic signed [PB-1:0] pos [3];
      logic [WB-1:0]        wire_n [3];
      logic [2:0]           mask;
   } hit_pair_type;

   logic clock, reset;
   logic req_valid, req_ready, req_op;
   logic [TIME_BITS-1:0] req_peak_time, req_sigma_time;
   logic signed [PB-1:0] req_pos_x, req_pos_y, req_pos_z;
   logic [WB-1:0] req_wire_u, req_wire_v, req_wire_w;
   logic [MASK_BITS-1:0] req_hit_mask;
   logic rsp_valid, rsp_consistent;
   logic rsp_ready = 1'b0;
   logic [SEP_BITS-1:0] rsp_separation;
   logic [WB-1:0] rsp_delta_min, rsp_delta_mid, rsp_delta_max;
   logic psel, penable, pwrite, pready;
   logic [ADDR_BITS-1:0] paddr;
   logic [DATA_BITS-1:0] pwdata, prdata;
   int errors, pending;
   int cycles = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int burst_left;
   hit_pair_type anchor;

   hit_pair_consistency_separation i_dut (.*);

   hpcs_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // response stall pattern: steady, random, mostly stalled
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(2);
         stall_left <= $urandom_range(300, 20);
      end else stall_left <= stall_left - 1;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(1));
         default: rsp_ready <= ($urandom_range(7) == 0);
      endcase
   end

   task automatic send(input hit_pair_type h);
      req_valid      <= 1'b1;
      req_op         <= h.op;
      req_peak_time  <= h.pt;
      req_sigma_time <= h.sg;
      req_pos_x      <= h.pos[0];
      req_pos_y      <= h.pos[1];
      req_pos_z      <= h.pos[2];
      req_wire_u     <= h.wire_n[0];
      req_wire_v     <= h.wire_n[1];
      req_wire_w     <= h.wire_n[2];
      req_hit_mask   <= h.mask;
      if (h.op == OP_LOAD) anchor = h;
      do @(posedge clock); while (!req_ready);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 1);
      end else burst_left--;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [ADDR_BITS-1:0] a, input logic [31:0] d);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic hit_pair_type random_pair(input logic op);
      hit_pair_type h;
      h.op = op;
      h.pt = TIME_BITS'($urandom); h.sg = TIME_BITS'($urandom);
      for (int i = 0; i < 3; i++) begin
         h.pos[i] = PB'($urandom);
         h.wire_n[i] = WB'($urandom);
      end
      h.mask = 3'($urandom);
      return h;
   endfunction

   function automatic hit_pair_type moderate_pair(input logic op);
      hit_pair_type h;
      h = random_pair(op);
      h.sg = TIME_BITS'($urandom_range(3000));
      h.pt = TIME_BITS'($urandom_range(250000, 10000));
      return h;
   endfunction

   function automatic hit_pair_type near_pair;
      hit_pair_type h;
      int dw;
      h = moderate_pair(OP_COMPARE);
      h.pt = TIME_BITS'(anchor.pt + $urandom_range(2 * h.sg + 64) - (h.sg + 32));
      for (int i = 0; i < 3; i++) begin
         h.pos[i] = PB'(anchor.pos[i] + $signed(PB'($urandom_range(8192))) - 4096);
         case ($urandom_range(5))
            0, 1: dw = $urandom_range(1);
            2:    dw = 2;
            3:    dw = $urandom_range(8, 3);
            4:    dw = 8;
            default: dw = $urandom_range(40);
         endcase
         h.wire_n[i] = $urandom_range(1) ? WB'(anchor.wire_n[i] + dw)
                                         : WB'(anchor.wire_n[i] - dw);
      end
      if ($urandom_range(7) == 0) h.pos[0] = anchor.pos[0] + 20'sd500000;
      return h;
   endfunction

   function automatic hit_pair_type directed_pair(input logic op, input int pt,
      input int sg, input int px, input int wu, input int wv, input int ww,
      input int mask);
      hit_pair_type h;
      h.op = op; h.pt = TIME_BITS'(pt); h.sg = TIME_BITS'(sg);
      h.pos[0] = PB'(px); h.pos[1] = PB'(-px); h.pos[2] = PB'(px / 2);
      h.wire_n[0] = WB'(wu); h.wire_n[1] = WB'(wv); h.wire_n[2] = WB'(ww);
      h.mask = 3'(mask);
      return h;
   endfunction

   initial begin
      hit_pair_type h;
      logic [SCALE_BITS-1:0] scales [5] = '{768, 0, 4095, 256, 1};
      logic [MINOV_BITS-1:0] floors [5] = '{6, 0, 255, 1, 0};
      burst_left = 0;
      reset = 1'b1; req_valid = 1'b0; req_op = 1'b0;
      req_peak_time = '0; req_sigma_time = '0;
      req_pos_x = '0; req_pos_y = '0; req_pos_z = '0;
      req_wire_u = '0; req_wire_v = '0; req_wire_w = '0; req_hit_mask = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
      paddr = '0; pwdata = '0;
      anchor = directed_pair(OP_LOAD, 0, 0, 0, 0, 0, 0, 0);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: compare against reset reference, extremes, neighbour edges
      send(directed_pair(OP_COMPARE, 0, 0, 0, 0, 0, 0, 0));
      send(directed_pair(OP_COMPARE, 0, 1000, 100, 1, 0, 1, 7));
      send(directed_pair(OP_LOAD, 5000, 100, 1000, 100, 100, 100, 0));
      send(directed_pair(OP_COMPARE, 5000, 100, 1000, 100, 100, 100, 0));
      send(directed_pair(OP_COMPARE, 5010, 80, 1300, 101, 101, 100, 7));
      send(directed_pair(OP_COMPARE, 5000, 100, 1000, 100, 102, 107, 1));
      send(directed_pair(OP_COMPARE, 5000, 100, 1000, 100, 102, 108, 2));
      send(directed_pair(OP_COMPARE, 5000, 100, 1000, 102, 102, 100, 4));
      send(directed_pair(OP_COMPARE, 5000, 0, 1000, 100, 100, 100, 0));
      send(directed_pair(OP_COMPARE, 5000, 100, -524288, 100, 100, 101, 0));
      send(directed_pair(OP_COMPARE, 200000, 100, 1000, 100, 100, 100, 0));
      send(directed_pair(OP_LOAD, 262143, 262143, 524287, 8191, 0, 8191, 7));
      send(directed_pair(OP_COMPARE, 262143, 262143, -524288, 8191, 1, 8190, 7));
      send(directed_pair(OP_COMPARE, 0, 262143, 0, 0, 8191, 0, 0));
      send(directed_pair(OP_COMPARE, 262143, 1, 524287, 8191, 0, 8191, 3));
      send(directed_pair(OP_LOAD, 0, 262143, -524288, 0, 8191, 0, 5));
      send(directed_pair(OP_COMPARE, 131072, 262143, 524287, 1, 8190, 0, 6));
      send(directed_pair(OP_COMPARE, 0, 262143, -524288, 0, 8191, 0, 5));
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         csr_write(ADDR_BITS'(4 * REG_SCALE),
                   ph == 4 ? $urandom_range(4095) : scales[ph]);
         csr_write(ADDR_BITS'(4 * REG_MINOV),
                   ph == 4 ? $urandom_range(255) : floors[ph]);
         for (int n = 0; n < 160; n++) begin
            case ($urandom_range(11))
               0:       send($urandom_range(2) == 0 ? random_pair(OP_LOAD)
                                                    : moderate_pair(OP_LOAD));
               1:       send(random_pair(OP_COMPARE));
               2:       send(moderate_pair(OP_COMPARE));
               default: send(near_pair());
            endcase
         end
         drain();
      end

      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
